// ===== rtl/core/mip_pkg.sv =====
// Package for the MED inverse prediction block: widths, register indexes
// and the median edge detector function. No dependencies.
`default_nettype none

package mip_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 8;
    localparam int RES_W     = 9;
    localparam int WID_W     = 13;
    localparam int HGT_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic [COL_W-1:0] t_col;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // Median edge detector: min(a,b) if c >= max(a,b), max(a,b) if
    // c <= min(a,b), otherwise a + b - c (always within 0..255 then).
    function automatic t_pixel med(input t_pixel a, input t_pixel b, input t_pixel c);
        t_pixel lo;
        t_pixel hi;
        t_pixel sum;
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        sum = t_pixel'(a + b - c);
        if (c >= hi) begin
            med = lo;
        end else if (c <= lo) begin
            med = hi;
        end else begin
            med = sum;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mip_line_buf.sv =====
// Line buffer for the MED inverse prediction block: one synchronous memory
// with a registered read and write-to-read forwarding. Uses mip_pkg.
`default_nettype none

module mip_line_buf (
    input  wire              i_clk,
    input  wire              i_wr_en,
    input  mip_pkg::t_col    i_wr_addr,
    input  mip_pkg::t_pixel  i_wr_data,
    input  mip_pkg::t_col    i_rd_addr,
    output mip_pkg::t_pixel  o_rd_data
);

    mip_pkg::t_pixel r_mem [mip_pkg::MAX_WIDTH];
    mip_pkg::t_pixel r_rd_data;
    mip_pkg::t_pixel r_fwd_data;
    logic            r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // A read of the entry being written in the same cycle returns the new data.
    always_ff @(posedge i_clk) begin
        r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
        r_fwd_data <= i_wr_data;
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/med_inverse_prediction.sv =====
// MED inverse prediction top level: rebuilds 8-bit greyscale pixels from
// signed residuals in raster order. Uses mip_pkg and mip_line_buf.
//
// Usage:
//   The slave stream carries one 9-bit signed residual per transfer, in raster
//   order. The master stream returns one reconstructed pixel per residual;
//   tlast marks the last pixel of the image. Image width and height are set
//   through the write port (index 0 width, index 1 height) while idle; a width
//   of zero counts as one and widths above 4096 count as 4096, a height of zero
//   counts as one.
//   Throughput is one pixel per cycle while tready is high. The line buffer is
//   read ahead at the next pixel's column, so the pixel above is ready when the
//   residual arrives; the prediction and add complete in the accept cycle and
//   the pixel is registered in the output register, or in the skid register if that one is held.
//   A two-entry output stage (output register plus skid register) keeps the
//   slave side independent of master tready: input is taken while a result
//   waits, and tready drops only once both entries are full.
//   Reset returns the counters to row 0, column 0 and the registers to 640 by
//   480, and holds tready low. The line buffer is not cleared; row 0 never
//   reads it.
`default_nettype none

module med_inverse_prediction (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [0:0]   i_cfg_addr,
    input  wire [15:0]  i_cfg_wdata,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [15:0]  i_s_axis_tdata,  // [8:0] residual, [15:9] zero
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [7:0] pixel_value
    output logic        o_m_axis_tlast
);

    logic [mip_pkg::WID_W-1:0] r_width;
    logic [mip_pkg::HGT_W-1:0] r_height;
    mip_pkg::t_col             r_col, n_col;
    logic [mip_pkg::HGT_W-1:0] r_row, n_row;
    mip_pkg::t_pixel           r_left;
    mip_pkg::t_pixel           r_upleft;

    logic                      accept;
    logic [mip_pkg::WID_W-1:0] eff_width;
    logic [mip_pkg::HGT_W-1:0] eff_height;
    logic                      end_row, end_img;
    mip_pkg::t_pixel           above, pred, pixel;
    logic [mip_pkg::RES_W-1:0] residual;

    logic                      r_out_valid, r_skid_valid;
    mip_pkg::t_pixel           r_out_pix, r_skid_pix;
    logic                      r_out_last, r_skid_last;
    logic                      out_take;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mip_pkg::WID_W'(640);
            r_height <= mip_pkg::HGT_W'(480);
        end else if (i_cfg_we) begin
            unique case (mip_pkg::t_cfg_idx'(i_cfg_addr))
                mip_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata[mip_pkg::WID_W-1:0];
                mip_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_wdata[mip_pkg::HGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            eff_width = mip_pkg::WID_W'(1);
        end else if (r_width > mip_pkg::WID_W'(mip_pkg::MAX_WIDTH)) begin
            eff_width = mip_pkg::WID_W'(mip_pkg::MAX_WIDTH);
        end else begin
            eff_width = r_width;
        end
        eff_height = (r_height == '0) ? mip_pkg::HGT_W'(1) : r_height;
    end

    assign o_s_axis_tready = i_rst_n && !r_skid_valid;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign residual        = i_s_axis_tdata[mip_pkg::RES_W-1:0];

    assign end_row = ({1'b0, r_col} + mip_pkg::WID_W'(1)) >= eff_width;
    assign end_img = end_row &&
                     (({1'b0, r_row} + 17'd1) >= {1'b0, eff_height});

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (end_row) begin
                n_col = '0;
                n_row = end_img ? '0 : r_row + mip_pkg::HGT_W'(1);
            end else begin
                n_col = r_col + mip_pkg::COL_W'(1);
            end
        end
    end

    // The buffer is always addressed with the next pixel's column.
    mip_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (pixel),
        .i_rd_addr (n_col),
        .o_rd_data (above)
    );

    always_comb begin
        if (r_row == '0 && r_col == '0) begin
            pred = '0;
        end else if (r_row == '0) begin
            pred = r_left;
        end else if (r_col == '0) begin
            pred = above;
        end else begin
            pred = mip_pkg::med(r_left, above, r_upleft);
        end
        // Only the low byte of the sum is kept, so the residual's sign bit drops out.
        pixel = pred + residual[mip_pkg::PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= '0;
            r_upleft <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_left   <= pixel;
                r_upleft <= above;
            end
        end
    end

    // Output register with skid entry.
    assign out_take = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_pix  <= r_skid_pix;
                r_out_last <= r_skid_last;
            end else if (accept) begin
                r_out_pix  <= pixel;
                r_out_last <= end_img;
            end
        end else if (accept) begin
            r_skid_pix  <= pixel;
            r_skid_last <= end_img;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_pix;
    assign o_m_axis_tlast  = r_out_last;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds data while output register is empty");

    a_accept_gives_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_axis_tvalid)
        else $error("accepted residual produced no output");

    a_image_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && end_img) |=> (r_col == '0 && r_row == '0))
        else $error("counters did not return to origin after last pixel");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !end_row) |=> ({1'b0, r_col} < eff_width))
        else $error("column count ran past image width");

endmodule

`default_nettype wire
